### hw/rtl/fsbm_pkg.sv
package fsbm_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int ENTRY_BITS  = 5;
    localparam int OFFSET_BITS = 40;
    localparam int LEN_BITS    = 16;
    localparam int BUF_BITS    = 22;
    localparam int BUDGET_BITS = 32;
    localparam int MAX_EVICT   = 32;
    localparam int EV_BITS     = $clog2(MAX_EVICT + 1);
    localparam int REC_BITS    = $clog2(MAX_EVICT);
    localparam int QDEPTH      = 4;
    localparam int QBITS       = $clog2(QDEPTH);

    localparam logic [2:0] FUNC_REGISTER   = 3'd0;
    localparam logic [2:0] FUNC_SPILL      = 3'd1;
    localparam logic [2:0] FUNC_FETCH      = 3'd2;
    localparam logic [2:0] FUNC_WRITE_BACK = 3'd3;
    localparam logic [2:0] FUNC_DROP_BUF   = 3'd4;
    localparam logic [2:0] FUNC_DROP_FILE  = 3'd5;
    localparam logic [2:0] FUNC_QUERY      = 3'd6;

    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_WRITE_FREE = 3'd1;
    localparam logic [2:0] CMD_FREE_BUF   = 3'd2;
    localparam logic [2:0] CMD_READ       = 3'd3;
    localparam logic [2:0] CMD_WRITE_KEEP = 3'd4;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_BAD_STATUS = 2'd1;
    localparam logic [1:0] ERR_NO_ROOM    = 2'd2;
    localparam logic [1:0] ERR_STORE_FULL = 2'd3;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_BUF     = 2'd1;
    localparam logic [1:0] ST_STORE   = 2'd2;
    localparam logic [1:0] ST_BOTH    = 2'd3;

    typedef enum logic [2:0] {
        OP_REGISTER,
        OP_SPILL,
        OP_FETCH,
        OP_WRITE_BACK,
        OP_DROP_BUF,
        OP_DROP_FILE,
        OP_QUERY
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EVICT,
        S_REMOVE,
        S_APPEND1,
        S_APPEND2,
        S_FINISH,
        S_DRAIN
    } seq_t;

    typedef struct packed {
        op_t                   op;
        logic                  ok;
        logic [ENTRY_BITS-1:0] entry;
        logic [LEN_BITS-1:0]   length;
    } req_t;

    typedef struct packed {
        logic [2:0]             cmd;
        logic [ENTRY_BITS-1:0]  entry;
        logic [OFFSET_BITS-1:0] offset;
        logic [LEN_BITS-1:0]    length;
    } rec_t;

    function automatic logic [ENTRY_BITS-1:0] idx(input logic [ENTRY_BITS-1:0] x);
        return (32'(x) < NUM_ENTRIES) ? x : '0;
    endfunction

endpackage

### hw/rtl/fsbm_front.sv
module fsbm_front import fsbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            func,
    input  logic [ENTRY_BITS-1:0] entry,
    input  logic [LEN_BITS-1:0]   length,
    output logic                  req_valid,
    output req_t                  req,
    input  logic                  req_take
);

    req_t             q_reg [QDEPTH];
    logic [QBITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QBITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QBITS:0]   count_reg, count_next;
    req_t             cls;
    logic             do_push;
    logic             do_pop;

    // classify: unknown function codes behave as query
    always_comb
    begin
        unique case (func)
            FUNC_REGISTER:   cls.op = OP_REGISTER;
            FUNC_SPILL:      cls.op = OP_SPILL;
            FUNC_FETCH:      cls.op = OP_FETCH;
            FUNC_WRITE_BACK: cls.op = OP_WRITE_BACK;
            FUNC_DROP_BUF:   cls.op = OP_DROP_BUF;
            FUNC_DROP_FILE:  cls.op = OP_DROP_FILE;
            default:         cls.op = OP_QUERY;
        endcase
        cls.ok     = 32'(entry) < NUM_ENTRIES;
        cls.entry  = entry;
        cls.length = length;
    end

    assign full      = (count_reg == (QBITS+1)'(QDEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QBITS+1)'(do_push) - (QBITS+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hw/rtl/fsbm_back.sv
module fsbm_back import fsbm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [BUDGET_BITS-1:0] budget,
    input  logic                   req_valid,
    input  req_t                   req,
    output logic                   req_take,
    output logic                   empty,
    input  logic                   pop,
    output logic [2:0]             command,
    output logic [ENTRY_BITS-1:0]  command_entry,
    output logic [OFFSET_BITS-1:0] command_offset,
    output logic [LEN_BITS-1:0]    command_length,
    output logic                   in_buffer,
    output logic                   in_store,
    output logic                   must_store,
    output logic [1:0]             error,
    output logic                   last
);

    seq_t state_reg, state_next, ret_reg, ret_next;
    op_t  op_reg, op_next;
    logic ok_reg, ok_next;
    logic [ENTRY_BITS-1:0]  e_reg, e_next, x_reg, x_next;
    logic [LEN_BITS-1:0]    len_reg, len_next, fl_len_reg, fl_len_next;
    logic [OFFSET_BITS-1:0] fl_off_reg, fl_off_next;
    logic                   must_reg, must_next;
    logic [1:0]             err_reg, err_next;
    rec_t                   fin_reg, fin_next;
    logic [EV_BITS-1:0]     ev_reg, ev_next, rd_reg, rd_next;
    logic                   fb_reg, fb_next, fs_reg, fs_next;
    logic [ENTRY_BITS-1:0]  head_reg, head_next;
    logic                   nonempty_reg, nonempty_next;
    logic [BUF_BITS-1:0]    buffered_reg, buffered_next;
    logic [OFFSET_BITS-1:0] store_end_reg, store_end_next;

    logic [1:0]             status_reg [NUM_ENTRIES];
    logic [LEN_BITS-1:0]    length_reg [NUM_ENTRIES];
    logic [OFFSET_BITS-1:0] offset_reg [NUM_ENTRIES];
    logic [ENTRY_BITS-1:0]  next_reg   [NUM_ENTRIES];
    logic [ENTRY_BITS-1:0]  prev_reg   [NUM_ENTRIES];
    rec_t                   rec_reg    [MAX_EVICT];

    logic                   out_full_reg, out_full_next;
    rec_t                   out_rec_reg, out_rec_next;
    logic                   out_fb_reg, out_fb_next, out_fs_reg, out_fs_next;
    logic                   out_must_reg, out_must_next;
    logic [1:0]             out_err_reg, out_err_next;
    logic                   out_last_reg, out_last_next;

    // table write ports, one per table and cycle
    logic st_we, ln_we, of_we, nx_we, pv_we, rc_we;
    logic [ENTRY_BITS-1:0]  st_wa, ln_wa, of_wa, nx_wa, pv_wa, nx_wd, pv_wd;
    logic [1:0]             st_wd;
    logic [LEN_BITS-1:0]    ln_wd;
    logic [OFFSET_BITS-1:0] of_wd;
    logic [REC_BITS-1:0]    rc_wa;
    rec_t                   rc_wd;

    // shared read address and reads
    logic [ENTRY_BITS-1:0]  ra;
    logic [1:0]             s_rd;
    logic [LEN_BITS-1:0]    l_rd;
    logic [OFFSET_BITS-1:0] o_rd;
    logic [ENTRY_BITS-1:0]  n_rd, p_rd;

    logic [LEN_BITS-1:0]    chk_len, fit_len, sub_len;
    logic                   over_budget;
    logic [OFFSET_BITS:0]   store_sum;
    logic                   fits;
    logic [BUF_BITS-1:0]    buf_sub;
    logic                   out_load;

    assign s_rd = status_reg[ra];
    assign l_rd = length_reg[ra];
    assign o_rd = offset_reg[ra];
    assign n_rd = idx(next_reg[ra]);
    assign p_rd = idx(prev_reg[ra]);

    assign over_budget = (33'(buffered_reg) + 33'(chk_len)) > 33'(budget);
    assign store_sum   = (OFFSET_BITS+1)'(store_end_reg) + (OFFSET_BITS+1)'(fit_len);
    assign fits        = !store_sum[OFFSET_BITS];
    assign buf_sub     = (buffered_reg >= BUF_BITS'(sub_len)) ?
                         buffered_reg - BUF_BITS'(sub_len) : '0;
    assign out_load    = !out_full_reg || pop;
    assign req_take    = (state_reg == S_IDLE) && req_valid;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        op_next        = op_reg;
        ok_next        = ok_reg;
        e_next         = e_reg;
        x_next         = x_reg;
        len_next       = len_reg;
        fl_len_next    = fl_len_reg;
        fl_off_next    = fl_off_reg;
        must_next      = must_reg;
        err_next       = err_reg;
        fin_next       = fin_reg;
        ev_next        = ev_reg;
        rd_next        = rd_reg;
        fb_next        = fb_reg;
        fs_next        = fs_reg;
        head_next      = head_reg;
        nonempty_next  = nonempty_reg;
        buffered_next  = buffered_reg;
        store_end_next = store_end_reg;
        out_full_next  = out_full_reg && !pop;
        out_rec_next   = out_rec_reg;
        out_fb_next    = out_fb_reg;
        out_fs_next    = out_fs_reg;
        out_must_next  = out_must_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        st_we = 1'b0; st_wa = e_reg; st_wd = ST_INVALID;
        ln_we = 1'b0; ln_wa = e_reg; ln_wd = len_reg;
        of_we = 1'b0; of_wa = e_reg; of_wd = store_end_reg;
        nx_we = 1'b0; nx_wa = x_reg; nx_wd = x_reg;
        pv_we = 1'b0; pv_wa = x_reg; pv_wd = x_reg;
        rc_we = 1'b0; rc_wa = ev_reg[REC_BITS-1:0]; rc_wd = '0;
        ra      = e_reg;
        chk_len = len_reg;
        fit_len = len_reg;
        sub_len = len_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.op;
                    ok_next    = req.ok;
                    e_next     = req.entry;
                    len_next   = req.length;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                must_next  = over_budget;
                err_next   = ERR_OK;
                fin_next   = '0;
                ev_next    = '0;
                x_next     = e_reg;
                ret_next   = S_FINISH;
                state_next = S_FINISH;
                if (!ok_reg)
                begin
                    err_next = ERR_BAD_STATUS;
                end
                else
                begin
                    unique case (op_reg)
                        OP_REGISTER:
                        begin
                            if (s_rd != ST_INVALID)
                            begin
                                err_next = ERR_BAD_STATUS;
                            end
                            else
                            begin
                                ln_we = 1'b1;
                                buffered_next = buffered_reg + BUF_BITS'(len_reg);
                                st_we = 1'b1; st_wd = ST_BUF;
                                state_next = S_APPEND1;
                            end
                        end
                        OP_SPILL:
                        begin
                            fit_len = (s_rd == ST_BUF) ? l_rd : len_reg;
                            sub_len = l_rd;
                            if (s_rd != ST_INVALID && s_rd != ST_BUF)
                            begin
                                err_next = ERR_BAD_STATUS;
                            end
                            else if (!fits)
                            begin
                                err_next = ERR_STORE_FULL;
                            end
                            else
                            begin
                                ln_we = 1'b1; ln_wd = fit_len;
                                of_we = 1'b1;
                                store_end_next = store_sum[OFFSET_BITS-1:0];
                                st_we = 1'b1; st_wd = ST_STORE;
                                fin_next.cmd    = CMD_WRITE_FREE;
                                fin_next.entry  = e_reg;
                                fin_next.offset = store_end_reg;
                                fin_next.length = fit_len;
                                if (s_rd == ST_BUF)
                                begin
                                    buffered_next = buf_sub;
                                    state_next    = S_REMOVE;
                                end
                            end
                        end
                        OP_FETCH:
                        begin
                            if (s_rd != ST_STORE)
                            begin
                                err_next = ERR_BAD_STATUS;
                            end
                            else if (32'(l_rd) > budget)
                            begin
                                err_next = ERR_NO_ROOM;
                            end
                            else
                            begin
                                fl_len_next = l_rd;
                                fl_off_next = o_rd;
                                state_next  = S_EVICT;
                            end
                        end
                        OP_WRITE_BACK:
                        begin
                            if (s_rd == ST_BOTH)
                            begin
                                fin_next.cmd    = CMD_WRITE_KEEP;
                                fin_next.entry  = e_reg;
                                fin_next.offset = o_rd;
                                fin_next.length = l_rd;
                            end
                        end
                        OP_DROP_BUF:
                        begin
                            sub_len = l_rd;
                            if (s_rd != ST_BUF && s_rd != ST_BOTH)
                            begin
                                err_next = ERR_BAD_STATUS;
                            end
                            else
                            begin
                                buffered_next = buf_sub;
                                st_we = 1'b1;
                                st_wd = (s_rd == ST_BOTH) ? ST_STORE : ST_INVALID;
                                fin_next.cmd    = CMD_FREE_BUF;
                                fin_next.entry  = e_reg;
                                fin_next.length = l_rd;
                                state_next = S_REMOVE;
                            end
                        end
                        OP_DROP_FILE:
                        begin
                            if (s_rd != ST_STORE)
                            begin
                                err_next = ERR_BAD_STATUS;
                            end
                            else
                            begin
                                st_we = 1'b1; st_wd = ST_INVALID;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_EVICT:
            begin
                ra      = head_reg;
                chk_len = fl_len_reg;
                fit_len = l_rd;
                sub_len = l_rd;
                x_next  = head_reg;
                if (!over_budget)
                begin
                    buffered_next = buffered_reg + BUF_BITS'(fl_len_reg);
                    st_we = 1'b1; st_wd = ST_BOTH;
                    fin_next.cmd    = CMD_READ;
                    fin_next.entry  = e_reg;
                    fin_next.offset = fl_off_reg;
                    fin_next.length = fl_len_reg;
                    x_next     = e_reg;
                    ret_next   = S_FINISH;
                    state_next = S_APPEND1;
                end
                else if (!nonempty_reg || ev_reg >= EV_BITS'(MAX_EVICT))
                begin
                    err_next   = ERR_NO_ROOM;
                    state_next = S_FINISH;
                end
                else if (s_rd == ST_BUF && !fits)
                begin
                    err_next   = ERR_STORE_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    // evict the oldest unit: spill it if it has no store copy
                    buffered_next = buf_sub;
                    st_we = 1'b1; st_wa = head_reg; st_wd = ST_STORE;
                    rc_we = 1'b1;
                    rc_wd.entry  = head_reg;
                    rc_wd.length = l_rd;
                    if (s_rd == ST_BUF)
                    begin
                        of_we = 1'b1; of_wa = head_reg;
                        store_end_next = store_sum[OFFSET_BITS-1:0];
                        rc_wd.cmd    = CMD_WRITE_FREE;
                        rc_wd.offset = store_end_reg;
                    end
                    else
                    begin
                        rc_wd.cmd = CMD_FREE_BUF;
                    end
                    ev_next    = ev_reg + 1'b1;
                    ret_next   = S_EVICT;
                    state_next = S_REMOVE;
                end
            end

            S_REMOVE:
            begin
                ra = x_reg;
                if (p_rd == x_reg)
                begin
                    nonempty_next = 1'b0;
                    head_next     = '0;
                end
                else
                begin
                    nx_we = 1'b1; nx_wa = p_rd; nx_wd = n_rd;
                    pv_we = 1'b1; pv_wa = n_rd; pv_wd = p_rd;
                    if (head_reg == x_reg)
                    begin
                        head_next = n_rd;
                    end
                end
                state_next = ret_reg;
            end

            S_APPEND1:
            begin
                ra = head_reg;
                if (!nonempty_reg)
                begin
                    head_next     = x_reg;
                    nonempty_next = 1'b1;
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    pv_we = 1'b1; pv_wd = p_rd;
                    nx_we = 1'b1; nx_wa = p_rd;
                    state_next = S_APPEND2;
                end
            end

            S_APPEND2:
            begin
                nx_we = 1'b1; nx_wd = head_reg;
                pv_we = 1'b1; pv_wa = head_reg;
                state_next = ret_reg;
            end

            S_FINISH:
            begin
                fb_next    = ok_reg && s_rd[0];
                fs_next    = ok_reg && s_rd[1];
                rd_next    = '0;
                state_next = S_DRAIN;
            end

            S_DRAIN:
            begin
                if (out_load)
                begin
                    out_full_next = 1'b1;
                    out_fb_next   = fb_reg;
                    out_fs_next   = fs_reg;
                    out_must_next = must_reg;
                    out_err_next  = err_reg;
                    if (rd_reg < ev_reg)
                    begin
                        out_rec_next  = rec_reg[rd_reg[REC_BITS-1:0]];
                        out_last_next = 1'b0;
                        rd_next       = rd_reg + 1'b1;
                    end
                    else
                    begin
                        out_rec_next  = fin_reg;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_FINISH;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            buffered_reg  <= '0;
            store_end_reg <= '0;
            out_full_reg  <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                status_reg[i] <= ST_INVALID;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            buffered_reg  <= buffered_next;
            store_end_reg <= store_end_next;
            out_full_reg  <= out_full_next;
            if (st_we)
            begin
                status_reg[st_wa] <= st_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ok_reg       <= ok_next;
        e_reg        <= e_next;
        x_reg        <= x_next;
        len_reg      <= len_next;
        fl_len_reg   <= fl_len_next;
        fl_off_reg   <= fl_off_next;
        must_reg     <= must_next;
        err_reg      <= err_next;
        fin_reg      <= fin_next;
        ev_reg       <= ev_next;
        rd_reg       <= rd_next;
        fb_reg       <= fb_next;
        fs_reg       <= fs_next;
        out_rec_reg  <= out_rec_next;
        out_fb_reg   <= out_fb_next;
        out_fs_reg   <= out_fs_next;
        out_must_reg <= out_must_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
        if (ln_we)
        begin
            length_reg[ln_wa] <= ln_wd;
        end
        if (of_we)
        begin
            offset_reg[of_wa] <= of_wd;
        end
        if (nx_we)
        begin
            next_reg[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_reg[pv_wa] <= pv_wd;
        end
        if (rc_we)
        begin
            rec_reg[rc_wa] <= rc_wd;
        end
    end

    assign empty          = !out_full_reg;
    assign command        = out_rec_reg.cmd;
    assign command_entry  = out_rec_reg.entry;
    assign command_offset = out_rec_reg.offset;
    assign command_length = out_rec_reg.length;
    assign in_buffer      = out_fb_reg;
    assign in_store       = out_fs_reg;
    assign must_store     = out_must_reg;
    assign error          = out_err_reg;
    assign last           = out_last_reg;

endmodule

### hw/rtl/fifo_spill_buffer_manager.sv
// Spill buffer manager: tracks data units held in a byte-budgeted buffer,
// in an append-only backing store, or both, and issues data-mover commands.
// Requests enter on push/full (func, entry, length); an item is taken when
// push is high and full is low. A four-deep request queue accepts items while
// the sequencer works on an earlier one.
// Results leave on empty/pop: each request yields its eviction commands and
// then one final result marked by last; status and error flags are the same
// on every result of a request.
// The budget register is written on cfg_valid/cfg_ready (ready is always high).
// The user must write it only while the block is idle; the block itself does
// not enforce this. The sequencer handles one request at a time: decode, then
// an unlink for spill of a buffered unit and for drop buffer, an append for
// register, and for a fetch that goes ahead an evict step and an unlink per
// eviction before its append; then finish and the drain of the results.
// Reset clears all unit status, the FIFO, the byte count and the store end,
// and sets the budget to 1048576. When the receiver holds pop low, drain
// stops at the output register; requests still queue until full rises.
module fifo_spill_buffer_manager import fsbm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [2:0]             func,
    input  logic [ENTRY_BITS-1:0]  entry,
    input  logic [LEN_BITS-1:0]    length,
    output logic                   empty,
    input  logic                   pop,
    output logic [2:0]             command,
    output logic [ENTRY_BITS-1:0]  command_entry,
    output logic [OFFSET_BITS-1:0] command_offset,
    output logic [LEN_BITS-1:0]    command_length,
    output logic                   in_buffer,
    output logic                   in_store,
    output logic                   must_store,
    output logic [1:0]             error,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [BUDGET_BITS-1:0] cfg_data
);

    logic [BUDGET_BITS-1:0] budget_reg;
    logic                   req_valid;
    logic                   req_take;
    req_t                   req;

    // accept budget writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_BITS'(1048576);
        end
        else if (cfg_valid)
        begin
            budget_reg <= cfg_data;
        end
    end

    // front: take and classify items into the request queue
    fsbm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .entry     (entry),
        .length    (length),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    // back: walk the tables, evict, and drain results
    fsbm_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .budget         (budget_reg),
        .req_valid      (req_valid),
        .req            (req),
        .req_take       (req_take),
        .empty          (empty),
        .pop            (pop),
        .command        (command),
        .command_entry  (command_entry),
        .command_offset (command_offset),
        .command_length (command_length),
        .in_buffer      (in_buffer),
        .in_store       (in_store),
        .must_store     (must_store),
        .error          (error),
        .last           (last)
    );

endmodule

### bench/fifo_spill_buffer_manager_tb.sv
module fifo_spill_buffer_manager_tb;
    import fsbm_pkg::*;

    // Expected result of one handshake on the result side.
    typedef struct {
        logic [2:0]             cmd;
        logic [ENTRY_BITS-1:0]  centry;
        logic [OFFSET_BITS-1:0] coff;
        logic [LEN_BITS-1:0]    clen;
        logic                   inbuf;
        logic                   instore;
        logic                   must;
        logic [1:0]             err;
        logic                   lst;
    } outcome_t;

    localparam logic [OFFSET_BITS:0] STORE_MASK = {1'b0, {OFFSET_BITS{1'b1}}};

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [2:0]             func;
    logic [ENTRY_BITS-1:0]  entry;
    logic [LEN_BITS-1:0]    length;
    logic                   empty;
    logic                   pop;
    logic [2:0]             command;
    logic [ENTRY_BITS-1:0]  command_entry;
    logic [OFFSET_BITS-1:0] command_offset;
    logic [LEN_BITS-1:0]    command_length;
    logic                   in_buffer;
    logic                   in_store;
    logic                   must_store;
    logic [1:0]             error;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [BUDGET_BITS-1:0] cfg_data;

    fifo_spill_buffer_manager u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .entry          (entry),
        .length         (length),
        .empty          (empty),
        .pop            (pop),
        .command        (command),
        .command_entry  (command_entry),
        .command_offset (command_offset),
        .command_length (command_length),
        .in_buffer      (in_buffer),
        .in_store       (in_store),
        .must_store     (must_store),
        .error          (error),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // Shadow copy of the unit tables and buffer bookkeeping.
    logic [BUDGET_BITS-1:0] budget;
    logic [1:0]             unit_status [NUM_ENTRIES];
    logic [LEN_BITS-1:0]    unit_len    [NUM_ENTRIES];
    logic [OFFSET_BITS-1:0] unit_off    [NUM_ENTRIES];
    logic [ENTRY_BITS-1:0]  ring_next   [NUM_ENTRIES];
    logic [ENTRY_BITS-1:0]  ring_prev   [NUM_ENTRIES];
    logic [ENTRY_BITS-1:0]  ring_head;
    logic                   ring_busy;
    logic [31:0]            held_bytes;
    logic [OFFSET_BITS-1:0] store_top;

    outcome_t pending_results[$];
    int       mismatches;
    int       hold_cycles;
    int       pop_stall;
    bit       no_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void ring_append(input logic [ENTRY_BITS-1:0] e);
        logic [ENTRY_BITS-1:0] t;
        if (!ring_busy)
        begin
            ring_head    = e;
            ring_next[e] = e;
            ring_prev[e] = e;
            ring_busy    = 1'b1;
        end
        else
        begin
            t = ring_prev[ring_head];
            ring_prev[e]         = t;
            ring_next[t]         = e;
            ring_next[e]         = ring_head;
            ring_prev[ring_head] = e;
        end
    endfunction

    // Unlink a unit from the arrival ring and release its bytes.
    function automatic void release_unit(input logic [ENTRY_BITS-1:0] e);
        logic [ENTRY_BITS-1:0] p;
        logic [ENTRY_BITS-1:0] n;
        p = ring_prev[e];
        n = ring_next[e];
        if (p == e)
        begin
            ring_busy = 1'b0;
            ring_head = '0;
        end
        else
        begin
            ring_next[p] = n;
            ring_prev[n] = p;
            if (ring_head == e)
                ring_head = n;
        end
        held_bytes = (held_bytes >= unit_len[e]) ? held_bytes - unit_len[e] : 0;
    endfunction

    function automatic bit store_has_room(input logic [31:0] len);
        return ({1'b0, store_top} + len) <= STORE_MASK;
    endfunction

    function automatic void store_unit(input logic [ENTRY_BITS-1:0] e);
        unit_off[e]    = store_top;
        store_top      = store_top + unit_len[e];
        unit_status[e] = ST_STORE;
    endfunction

    function automatic void reset_shadow();
        budget     = 32'd1048576;
        ring_head  = '0;
        ring_busy  = 1'b0;
        held_bytes = 0;
        store_top  = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            unit_status[i] = ST_INVALID;
            unit_len[i]    = '0;
            unit_off[i]    = '0;
            ring_next[i]   = '0;
            ring_prev[i]   = '0;
        end
    endfunction

    // Work out the results of one accepted item and queue them.
    function automatic void predict_commands(input logic [2:0] f,
                                             input logic [ENTRY_BITS-1:0] e,
                                             input logic [LEN_BITS-1:0] len);
        outcome_t               moves[$];
        outcome_t               r;
        logic [1:0]             err;
        logic [2:0]             cmd;
        logic [OFFSET_BITS-1:0] coff;
        logic [31:0]            clen;
        logic [31:0]            ulen;
        logic [1:0]             s;
        logic [ENTRY_BITS-1:0]  h;
        logic                   must;
        int                     evicted;
        err  = ERR_OK;
        cmd  = CMD_NONE;
        coff = '0;
        clen = 0;
        must = ({1'b0, held_bytes} + len) > {1'b0, budget};
        s    = unit_status[e];
        r    = '{default: '0};
        case (f)
            FUNC_REGISTER:
            begin
                if (s != ST_INVALID)
                    err = ERR_BAD_STATUS;
                else
                begin
                    unit_len[e]    = len;
                    held_bytes     = held_bytes + len;
                    unit_status[e] = ST_BUF;
                    ring_append(e);
                end
            end
            FUNC_SPILL:
            begin
                ulen = (s == ST_BUF) ? unit_len[e] : len;
                if (s != ST_INVALID && s != ST_BUF)
                    err = ERR_BAD_STATUS;
                else if (!store_has_room(ulen))
                    err = ERR_STORE_FULL;
                else
                begin
                    if (s == ST_BUF)
                        release_unit(e);
                    unit_len[e] = ulen[LEN_BITS-1:0];
                    store_unit(e);
                    cmd  = CMD_WRITE_FREE;
                    coff = unit_off[e];
                    clen = ulen;
                end
            end
            FUNC_FETCH:
            begin
                ulen = unit_len[e];
                if (s != ST_STORE)
                    err = ERR_BAD_STATUS;
                else if (ulen > budget)
                    err = ERR_NO_ROOM;
                else
                begin
                    evicted = 0;
                    // Evict from the oldest end until the fetched unit fits.
                    while (({1'b0, held_bytes} + ulen) > {1'b0, budget})
                    begin
                        if (!ring_busy || evicted >= MAX_EVICT)
                        begin
                            err = ERR_NO_ROOM;
                            break;
                        end
                        h = ring_head;
                        r.centry = h;
                        r.clen   = unit_len[h];
                        if (unit_status[h] == ST_BUF)
                        begin
                            if (!store_has_room(unit_len[h]))
                            begin
                                err = ERR_STORE_FULL;
                                break;
                            end
                            release_unit(h);
                            store_unit(h);
                            r.cmd  = CMD_WRITE_FREE;
                            r.coff = unit_off[h];
                        end
                        else
                        begin
                            release_unit(h);
                            unit_status[h] = ST_STORE;
                            r.cmd  = CMD_FREE_BUF;
                            r.coff = '0;
                        end
                        moves.push_back(r);
                        evicted++;
                    end
                    if (err == ERR_OK)
                    begin
                        held_bytes     = held_bytes + ulen;
                        unit_status[e] = ST_BOTH;
                        ring_append(e);
                        cmd  = CMD_READ;
                        coff = unit_off[e];
                        clen = ulen;
                    end
                end
            end
            FUNC_WRITE_BACK:
            begin
                if (s == ST_BOTH)
                begin
                    cmd  = CMD_WRITE_KEEP;
                    coff = unit_off[e];
                    clen = unit_len[e];
                end
            end
            FUNC_DROP_BUF:
            begin
                if (s != ST_BUF && s != ST_BOTH)
                    err = ERR_BAD_STATUS;
                else
                begin
                    release_unit(e);
                    unit_status[e] = (s == ST_BOTH) ? ST_STORE : ST_INVALID;
                    cmd  = CMD_FREE_BUF;
                    clen = unit_len[e];
                end
            end
            FUNC_DROP_FILE:
            begin
                if (s != ST_STORE)
                    err = ERR_BAD_STATUS;
                else
                    unit_status[e] = ST_INVALID;
            end
            default: ;
        endcase
        r.cmd    = cmd;
        r.centry = (cmd != CMD_NONE) ? e : '0;
        r.coff   = (cmd != CMD_NONE) ? coff : '0;
        r.clen   = (cmd != CMD_NONE) ? clen[LEN_BITS-1:0] : '0;
        moves.push_back(r);
        // Status and error flags are common to every result of the item.
        foreach (moves[i])
        begin
            moves[i].inbuf   = unit_status[e][0];
            moves[i].instore = unit_status[e][1];
            moves[i].must    = must;
            moves[i].err     = err;
            moves[i].lst     = (i == moves.size() - 1);
            pending_results.push_back(moves[i]);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Result side: drive pop with random stalls and check each item taken.
    always @(posedge clk)
    begin
        outcome_t x;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                x = pending_results.pop_front();
                if (command !== x.cmd || command_entry !== x.centry ||
                    command_offset !== x.coff || command_length !== x.clen)
                    report_mismatch($sformatf(
                        "command %0d/%0d/%0h/%0d expected %0d/%0d/%0h/%0d",
                        command, command_entry, command_offset, command_length,
                        x.cmd, x.centry, x.coff, x.clen));
                if (in_buffer !== x.inbuf || in_store !== x.instore ||
                    must_store !== x.must || error !== x.err || last !== x.lst)
                    report_mismatch($sformatf(
                        "flags buf%b st%b must%b err%0d last%b expected %b %b %b %0d %b",
                        in_buffer, in_store, must_store, error, last,
                        x.inbuf, x.instore, x.must, x.err, x.lst));
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            pop <= 1'b0;
        end
        else if (pop_stall > 0)
        begin
            pop_stall--;
            pop <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            pop_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Offer one item, hold it until accepted, then sometimes idle for a random gap.
    task automatic send_item(input logic [2:0] f, input logic [ENTRY_BITS-1:0] e,
                             input logic [LEN_BITS-1:0] len);
        int gap;
        push   <= 1'b1;
        func   <= f;
        entry  <= e;
        length <= len;
        do
            @(posedge clk);
        while (full);
        predict_commands(f, e, len);
        gap = 0;
        if (!no_idle)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = $urandom_range(1, 3);
                3:       gap = $urandom_range(8, 30);
                default: gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_budget(input logic [BUDGET_BITS-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        budget = value;
    endtask

    function automatic logic [LEN_BITS-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return LEN_BITS'($urandom_range(0, 255));
            default: return LEN_BITS'($urandom);
        endcase
    endfunction

    // Pick an operation that mostly suits the current state of the unit.
    task automatic send_random_item();
        logic [ENTRY_BITS-1:0] e;
        logic [2:0]            f;
        int                    r;
        e = ENTRY_BITS'($urandom_range(0, NUM_ENTRIES - 1));
        r = $urandom_range(0, 99);
        if (r < 8)
            f = 3'($urandom_range(0, 7));
        else
        begin
            case (unit_status[e])
                ST_INVALID: f = (r < 70) ? FUNC_REGISTER : FUNC_SPILL;
                ST_BUF:
                    f = (r < 45) ? FUNC_SPILL : (r < 65) ? FUNC_DROP_BUF :
                        (r < 80) ? FUNC_WRITE_BACK : (r < 90) ? FUNC_QUERY
                                                              : FUNC_REGISTER;
                ST_STORE:
                    f = (r < 70) ? FUNC_FETCH : (r < 85) ? FUNC_DROP_FILE
                                                         : FUNC_QUERY;
                default:
                    f = (r < 45) ? FUNC_WRITE_BACK : (r < 80) ? FUNC_DROP_BUF
                                                              : FUNC_FETCH;
            endcase
        end
        send_item(f, e, pick_length());
    endtask

    // Every operation, status errors, length extremes and the unknown func.
    task automatic test_directed_ops();
        send_item(FUNC_QUERY, 5'd0, 16'd0);
        send_item(FUNC_REGISTER, 5'd0, 16'd0);
        send_item(FUNC_REGISTER, 5'd31, 16'hFFFF);
        send_item(FUNC_REGISTER, 5'd0, 16'd7);
        send_item(FUNC_SPILL, 5'd31, 16'd0);
        send_item(FUNC_SPILL, 5'd31, 16'd0);
        send_item(FUNC_SPILL, 5'd2, 16'd100);
        send_item(FUNC_FETCH, 5'd2, 16'd0);
        send_item(FUNC_FETCH, 5'd0, 16'd0);
        send_item(FUNC_WRITE_BACK, 5'd2, 16'd0);
        send_item(FUNC_WRITE_BACK, 5'd0, 16'd0);
        send_item(FUNC_DROP_BUF, 5'd2, 16'd0);
        send_item(FUNC_DROP_BUF, 5'd3, 16'd0);
        send_item(FUNC_DROP_FILE, 5'd2, 16'd0);
        send_item(FUNC_DROP_FILE, 5'd2, 16'd0);
        send_item(3'd7, 5'd31, 16'hFFFF);
        send_item(FUNC_DROP_BUF, 5'd0, 16'hFFFF);
    endtask

    // Tiny budgets: fetches too large and an eviction that spills a buffered unit.
    task automatic test_budget_limits();
        write_budget(32'd0);
        send_item(FUNC_FETCH, 5'd31, 16'd0);
        send_item(FUNC_REGISTER, 5'd4, 16'd10);
        send_item(FUNC_SPILL, 5'd5, 16'd0);
        send_item(FUNC_FETCH, 5'd5, 16'd0);
        write_budget(32'd300);
        send_item(FUNC_REGISTER, 5'd6, 16'd200);
        send_item(FUNC_SPILL, 5'd7, 16'd50);
        send_item(FUNC_FETCH, 5'd7, 16'd0);
        send_item(FUNC_FETCH, 5'd31, 16'd0);
        write_budget('1);
    endtask

    // Hold pop low long enough that the request queue fills and full rises.
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            send_item(FUNC_QUERY, ENTRY_BITS'(i), LEN_BITS'($urandom));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_item();
    endtask

    initial
    begin
        reset_shadow();
        mismatches  = 0;
        hold_cycles = 0;
        pop_stall   = 0;
        no_idle     = 1'b0;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        pop       <= 1'b0;
        func      <= '0;
        entry     <= '0;
        length    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_budget_limits();
        test_backpressure();
        write_budget(32'd1048576);
        test_random_traffic(100);
        write_budget(32'd150000);
        test_random_traffic(100);
        no_idle = 1'b1;
        test_random_traffic(60);
        no_idle = 1'b0;
        write_budget(32'd40000);
        test_random_traffic(100);
        write_budget('1);
        test_random_traffic(80);
        drain_results();
        if (mismatches == 0)
            $display("fifo_spill_buffer_manager_tb: PASS");
        else
            $display("fifo_spill_buffer_manager_tb: FAIL");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("fifo_spill_buffer_manager_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/fsbm_pkg.sv
hw/rtl/fsbm_front.sv
hw/rtl/fsbm_back.sv
hw/rtl/fifo_spill_buffer_manager.sv
bench/fifo_spill_buffer_manager_tb.sv
